// ===== rtl/particle_motion_update_top_defines.svh =====
// Assertion macros for the particle motion update block.
// Used by particle_motion_update_top.sv; needs clk and arst_n in scope.
`ifndef PARTICLE_MOTION_UPDATE_TOP_DEFINES_SVH
`define PARTICLE_MOTION_UPDATE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PMU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define PMU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PMU_ASSERT_IMP(lbl, ante, cons, msg)
`define PMU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/pmu_pkg.sv =====
// Shared types and register codes for the particle motion update block.
// No dependencies.
package pmu_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_MASS   = 3'd0,
		REG_PULL   = 3'd1,
		REG_FRATE  = 3'd2,
		REG_FIRST  = 3'd3,
		REG_LAST   = 3'd4,
		REG_ORG_X  = 3'd5,
		REG_ORG_Y  = 3'd6,
		REG_ORG_Z  = 3'd7
	} reg_idx_t;

	// particle record as it travels down the pipeline
	typedef struct packed {
		logic             alive;
		logic             far;
		logic [2:0]       neg;
		logic [30:0]      age;
		logic [30:0]      dt;
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
		logic [31:0]      angle;
		logic [31:0]      spin;
		logic [15:0]      frame;
	} ctx_t;

endpackage

// ===== rtl/particle_motion_update_top.sv =====
// Particle motion update: Euler step of one particle record per beat.
// Depends on pmu_pkg and particle_motion_update_top_defines.svh.
//
// One particle beat is taken in every cycle (busy stays low); each result
// comes out on done exactly 46+FRAC_BITS cycles after its start beat, in
// order, and must be taken in that cycle since the receiver cannot stall.
// The latency is set by the 31-step square root of the unit-vector pull and
// the FRAC_BITS+2 step dividers behind it; the frame counter modulo runs
// alongside. Configuration must not change while beats are in flight.
`include "particle_motion_update_top_defines.svh"

module particle_motion_update_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic [30:0]        time_step,
	input  logic [30:0]        age_in,
	input  logic [30:0]        life_span,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] vel_z,
	input  logic signed [31:0] angle_in,
	input  logic signed [31:0] spin_rate,
	input  logic [15:0]        frame_in,
	// result channel
	output logic               done,
	output logic               still_alive,
	output logic [30:0]        age_out,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_pos_z,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_vel_z,
	output logic signed [31:0] angle_out,
	output logic [15:0]        frame_out,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import pmu_pkg::*;

	localparam longint unsigned GRAV = ((64'd981 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam int GW = $clog2(GRAV + 1);
	localparam logic [GW-1:0] GRAV_C = GW'(GRAV);
	localparam longint unsigned NEAR = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
	localparam logic [65:0] NEAR_SQ = 66'(NEAR * NEAR);
	localparam int MPW = 33 + GW;
	localparam int QB = FRAC_BITS + 2;
	localparam int UPW = QB + 33;
	localparam int NW = 62 - 2 * FRAC_BITS;
	// stage numbers
	localparam int S_SQ0 = 6;
	localparam int S_RT = S_SQ0 + 31;
	localparam int S_DV0 = S_RT + 1;
	localparam int S_DQ = S_DV0 + QB;
	localparam int S_P1 = S_DQ + 1;
	localparam int S_P2 = S_DQ + 2;
	localparam int S_P3 = S_DQ + 3;
	localparam int S_P4 = S_DQ + 4;
	localparam int S_P5 = S_DQ + 5;
	localparam int S_OUT = S_DQ + 6;
	localparam int S_MD0 = 4;
	localparam int S_MDE = S_MD0 + NW;

	// floor shift by FRAC_BITS and clamp to 32 bits
	function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p >>> FRAC_BITS;
		if (s > 64'sd2147483647)
			return 32'sh7fffffff;
		else if (s < -64'sd2147483648)
			return 32'sh80000000;
		else
			return s[31:0];
	endfunction

	function automatic logic signed [31:0] sclamp(input logic signed [32:0] s);
		if (s[32] != s[31])
			return s[32] ? 32'sh80000000 : 32'sh7fffffff;
		else
			return s[31:0];
	endfunction

	function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sclamp({a[31], a} + {b[31], b});
	endfunction

	function automatic logic signed [31:0] ssub(input logic signed [31:0] a,
		input logic signed [31:0] b);
		return sclamp({a[31], a} - {b[31], b});
	endfunction

	// ---------------- configuration registers ----------------
	logic signed [31:0] mass_q, pull_q, org_x_q, org_y_q, org_z_q;
	logic [30:0]        frate_q;
	logic [15:0]        first_q, last_q;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q  <= '0;
			pull_q  <= '0;
			frate_q <= '0;
			first_q <= '0;
			last_q  <= '0;
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MASS:  mass_q  <= pwdata;
				REG_PULL:  pull_q  <= pwdata;
				REG_FRATE: frate_q <= pwdata[30:0];
				REG_FIRST: first_q <= pwdata[15:0];
				REG_LAST:  last_q  <= pwdata[15:0];
				REG_ORG_X: org_x_q <= pwdata;
				REG_ORG_Y: org_y_q <= pwdata;
				REG_ORG_Z: org_z_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MASS:  prdata = mass_q;
			REG_PULL:  prdata = pull_q;
			REG_FRATE: prdata = {1'b0, frate_q};
			REG_FIRST: prdata = {16'd0, first_q};
			REG_LAST:  prdata = {16'd0, last_q};
			REG_ORG_X: prdata = org_x_q;
			REG_ORG_Y: prdata = org_y_q;
			REG_ORG_Z: prdata = org_z_q;
			default:   prdata = '0;
		endcase
	end

	// frame window; the user must keep it static while beats are in flight, the block does not enforce this
	logic        fen;
	logic [16:0] ftotal;
	assign fen = (frate_q != '0) && (last_q > first_q);
	assign ftotal = {1'b0, last_q} - {1'b0, first_q} + 17'd1;

	// ---------------- pipeline storage ----------------
	logic               acc;
	logic [1:S_OUT]     v_s;
	ctx_t               ctx_s [1:S_P5];
	logic [2:0][31:0]   mag_s1, mag_s2, mag_s3;
	logic [2:0][63:0]   sqm_s2;
	logic [31:0]        mmax_s2;
	logic signed [MPW-1:0] mp_s2;
	logic signed [63:0] ap_s2;
	logic [61:0]        fp_s2;
	logic [4:0]         msb_s3;
	logic signed [31:0] mq1_s3;
	logic [NW-1:0]      nn_s3;
	logic [2:0][29:0]   nrm_s [4:S_RT];
	logic signed [63:0] mp2_s4;
	logic [2:0][59:0]   nsq_s5;
	logic [61:0]        sq_n_s [S_SQ0:S_RT];
	logic [34:0]        sq_rem_s [S_SQ0:S_RT];
	logic [30:0]        sq_root_s [S_SQ0:S_RT];
	logic [2:0][31:0]   dv_rem_s [S_DV0:S_DQ];
	logic [2:0][QB-1:0] dv_q_s [S_DV0:S_DQ];
	logic [2:0][QB-1:0] dv_lo_s [S_DV0:S_DQ];
	logic [30:0]        dv_r_s [S_DV0:S_DQ];
	logic [16:0]        md_rem_s [S_MD0:S_P5];
	logic [NW-1:0]      md_n_s [S_MD0:S_P5];
	logic signed [UPW-1:0] pu_s [3];   // stage S_P1
	logic signed [31:0] pq_s [3];      // stage S_P2
	logic signed [63:0] pp_s [3];      // stage S_P3
	logic signed [63:0] vp_s [3];      // stage S_P5

	assign acc = start && !busy;
	assign busy = 1'b0;

	// ---------------- stage 1: age, lifetime, offset to origin ----------------
	ctx_t             ctx_d1;
	logic [2:0][31:0] mag_d1;
	logic [31:0]      age_sum;
	logic [2:0][31:0] org_v;
	logic [2:0][32:0] diff, ndiff;

	always_comb begin
		age_sum = {1'b0, time_step} + {1'b0, age_in};
		ctx_d1.age = age_sum[31] ? 31'h7fffffff : age_sum[30:0];
		ctx_d1.alive = ctx_d1.age < life_span;
		ctx_d1.far = 1'b0;
		ctx_d1.dt = time_step;
		ctx_d1.pos = {pos_z, pos_y, pos_x};
		ctx_d1.vel = {vel_z, vel_y, vel_x};
		ctx_d1.angle = angle_in;
		ctx_d1.spin = spin_rate;
		ctx_d1.frame = frame_in;
		org_v = {org_z_q, org_y_q, org_x_q};
		for (int i = 0; i < 3; i++) begin
			diff[i] = {org_v[i][31], org_v[i]} - {ctx_d1.pos[i][31], ctx_d1.pos[i]};
			ndiff[i] = -diff[i];
			ctx_d1.neg[i] = diff[i][32];
			mag_d1[i] = diff[i][32] ? ndiff[i][31:0] : diff[i][31:0];
		end
	end

	// ---------------- per-stage combinational steps ----------------
	logic [31:0]        mmax_d;
	logic [65:0]        dsum_d;
	logic [4:0]         msb_d;
	logic [2:0][31:0]   shf_d;
	logic [2:0][29:0]   nrm_d;
	logic [34:0]        sq_t [S_SQ0+1:S_RT];
	logic [34:0]        sq_tr [S_SQ0+1:S_RT];
	logic [34:0]        sq_rem_d [S_SQ0+1:S_RT];
	logic [30:0]        sq_root_d [S_SQ0+1:S_RT];
	logic [2:0][31:0]   dv_t [S_DV0+1:S_DQ];
	logic [2:0][31:0]   dv_rem_d [S_DV0+1:S_DQ];
	logic [2:0][QB-1:0] dv_q_d [S_DV0+1:S_DQ];
	logic [17:0]        md_t [S_MD0+1:S_MDE];
	logic [16:0]        md_rem_d [S_MD0+1:S_MDE];
	logic signed [QB:0] u_d [3];

	always_comb begin
		// largest offset magnitude
		mmax_d = mag_s1[0];
		if (mag_s1[1] > mmax_d) mmax_d = mag_s1[1];
		if (mag_s1[2] > mmax_d) mmax_d = mag_s1[2];
		// squared distance and leading one of the largest offset
		dsum_d = {2'b00, sqm_s2[0]} + {2'b00, sqm_s2[1]} + {2'b00, sqm_s2[2]};
		msb_d = '0;
		for (int j = 0; j < 32; j++)
			if (mmax_s2[j]) msb_d = 5'(j);
		// shift offsets so the largest lies in [2^29, 2^30)
		for (int i = 0; i < 3; i++) begin
			if (msb_s3 > 5'd29)
				shf_d[i] = mag_s3[i] >> (msb_s3 - 5'd29);
			else
				shf_d[i] = mag_s3[i] << (5'd29 - msb_s3);
			nrm_d[i] = shf_d[i][29:0];
		end
		// square root, two radicand bits per stage
		for (int k = S_SQ0 + 1; k <= S_RT; k++) begin
			sq_t[k] = {sq_rem_s[k-1][32:0], sq_n_s[k-1][61:60]};
			sq_tr[k] = {2'b00, sq_root_s[k-1], 2'b01};
			if (sq_t[k] >= sq_tr[k]) begin
				sq_rem_d[k] = sq_t[k] - sq_tr[k];
				sq_root_d[k] = {sq_root_s[k-1][29:0], 1'b1};
			end else begin
				sq_rem_d[k] = sq_t[k];
				sq_root_d[k] = {sq_root_s[k-1][29:0], 1'b0};
			end
		end
		// unit vector dividers, one quotient bit per stage
		for (int k = S_DV0 + 1; k <= S_DQ; k++) begin
			for (int i = 0; i < 3; i++) begin
				dv_t[k][i] = {dv_rem_s[k-1][i][30:0], dv_lo_s[k-1][i][QB-1]};
				if (dv_t[k][i] >= {1'b0, dv_r_s[k-1]}) begin
					dv_rem_d[k][i] = dv_t[k][i] - {1'b0, dv_r_s[k-1]};
					dv_q_d[k][i] = {dv_q_s[k-1][i][QB-2:0], 1'b1};
				end else begin
					dv_rem_d[k][i] = dv_t[k][i];
					dv_q_d[k][i] = {dv_q_s[k-1][i][QB-2:0], 1'b0};
				end
			end
		end
		// frame count modulo, one bit per stage
		for (int k = S_MD0 + 1; k <= S_MDE; k++) begin
			md_t[k] = {md_rem_s[k-1], md_n_s[k-1][NW-1]};
			if (md_t[k] >= {1'b0, ftotal})
				md_rem_d[k] = 17'(md_t[k] - {1'b0, ftotal});
			else
				md_rem_d[k] = md_t[k][16:0];
		end
		// signed unit component
		for (int i = 0; i < 3; i++) begin
			if (ctx_s[S_DQ].neg[i])
				u_d[i] = -$signed({1'b0, dv_q_s[S_DQ][i]});
			else
				u_d[i] = $signed({1'b0, dv_q_s[S_DQ][i]});
		end
	end

	// ---------------- record updates at fixed stages ----------------
	ctx_t ctx_n3, ctx_n5, ctx_np4;

	always_comb begin
		// stage 3: distance test, new angle
		ctx_n3 = ctx_s[2];
		ctx_n3.far = dsum_d > NEAR_SQ;
		if (ctx_s[2].alive)
			ctx_n3.angle = sadd(ctx_s[2].angle, qsat(ap_s2));
		// stage 5: gravity applied to z velocity
		ctx_n5 = ctx_s[4];
		if (ctx_s[4].alive)
			ctx_n5.vel[2] = ssub(ctx_s[4].vel[2], qsat(mp2_s4));
		// pull toward origin added to velocity
		ctx_np4 = ctx_s[S_P3];
		for (int i = 0; i < 3; i++)
			if (ctx_s[S_P3].alive && ctx_s[S_P3].far)
				ctx_np4.vel[i] = sadd(ctx_s[S_P3].vel[i], qsat(pp_s[i]));
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {acc, v_s[1:S_OUT-1]};
		end
	end

	// ---------------- payload registers ----------------
	logic               alive_sout;
	logic [30:0]        age_sout;
	logic [2:0][31:0]   pos_sout, vel_sout;
	logic [31:0]        angle_sout;
	logic [15:0]        frame_sout;

	always_ff @(posedge clk) begin
		// record travels down, taking the stage updates where they apply
		ctx_s[1] <= ctx_d1;
		for (int k = 2; k <= S_P5; k++) begin
			if (k == 3)
				ctx_s[k] <= ctx_n3;
			else if (k == 5)
				ctx_s[k] <= ctx_n5;
			else if (k == S_P4)
				ctx_s[k] <= ctx_np4;
			else
				ctx_s[k] <= ctx_s[k-1];
		end
		mag_s1 <= mag_d1;

		// stage 2: squares, gravity and spin products, frame product
		for (int i = 0; i < 3; i++)
			sqm_s2[i] <= mag_s1[i] * mag_s1[i];
		mmax_s2 <= mmax_d;
		mag_s2 <= mag_s1;
		mp_s2 <= mass_q * $signed({1'b0, GRAV_C});
		ap_s2 <= $signed(ctx_s[1].spin) * $signed({1'b0, ctx_s[1].dt});
		fp_s2 <= ctx_s[1].age * frate_q;

		// stage 3: frame count, first gravity product
		mag_s3 <= mag_s2;
		msb_s3 <= msb_d;
		mq1_s3 <= qsat(64'(mp_s2));
		nn_s3 <= fp_s2[61:2*FRAC_BITS];

		// stage 4: normalized offsets, gravity times step
		nrm_s[4] <= nrm_d;
		for (int k = 5; k <= S_RT; k++)
			nrm_s[k] <= nrm_s[k-1];
		mp2_s4 <= mq1_s3 * $signed({1'b0, ctx_s[3].dt});

		// stage 5: squares of normalized offsets
		for (int i = 0; i < 3; i++)
			nsq_s5[i] <= nrm_s[4][i] * nrm_s[4][i];

		// square root pipeline
		sq_n_s[S_SQ0] <= {2'b00, nsq_s5[0]} + {2'b00, nsq_s5[1]} + {2'b00, nsq_s5[2]};
		sq_rem_s[S_SQ0] <= '0;
		sq_root_s[S_SQ0] <= '0;
		for (int k = S_SQ0 + 1; k <= S_RT; k++) begin
			sq_n_s[k] <= {sq_n_s[k-1][59:0], 2'b00};
			sq_rem_s[k] <= sq_rem_d[k];
			sq_root_s[k] <= sq_root_d[k];
		end

		// divider pipeline: (offset << FRAC_BITS) / root
		for (int i = 0; i < 3; i++) begin
			dv_rem_s[S_DV0][i] <= {4'd0, nrm_s[S_RT][i][29:2]};
			dv_lo_s[S_DV0][i] <= {nrm_s[S_RT][i][1:0], {FRAC_BITS{1'b0}}};
		end
		dv_q_s[S_DV0] <= '0;
		dv_r_s[S_DV0] <= sq_root_s[S_RT];
		for (int k = S_DV0 + 1; k <= S_DQ; k++) begin
			dv_rem_s[k] <= dv_rem_d[k];
			dv_q_s[k] <= dv_q_d[k];
			for (int i = 0; i < 3; i++)
				dv_lo_s[k][i] <= {dv_lo_s[k-1][i][QB-2:0], 1'b0};
			dv_r_s[k] <= dv_r_s[k-1];
		end

		// frame modulo pipeline, then carried to the output
		md_rem_s[S_MD0] <= '0;
		md_n_s[S_MD0] <= nn_s3;
		for (int k = S_MD0 + 1; k <= S_P5; k++) begin
			if (k <= S_MDE) begin
				md_rem_s[k] <= md_rem_d[k];
				md_n_s[k] <= {md_n_s[k-1][NW-2:0], 1'b0};
			end else begin
				md_rem_s[k] <= md_rem_s[k-1];
				md_n_s[k] <= md_n_s[k-1];
			end
		end

		// pull products qmul(qmul(u, pull), dt), then velocity times step
		for (int i = 0; i < 3; i++) begin
			pu_s[i] <= u_d[i] * pull_q;
			pq_s[i] <= qsat(64'(pu_s[i]));
			pp_s[i] <= pq_s[i] * $signed({1'b0, ctx_s[S_P2].dt});
			vp_s[i] <= $signed(ctx_s[S_P4].vel[i]) * $signed({1'b0, ctx_s[S_P4].dt});
		end

		// output stage: position and frame updated, rest of the record registered as is
		alive_sout <= ctx_s[S_P5].alive;
		age_sout <= ctx_s[S_P5].age;
		vel_sout <= ctx_s[S_P5].vel;
		angle_sout <= ctx_s[S_P5].angle;
		for (int i = 0; i < 3; i++) begin
			if (ctx_s[S_P5].alive)
				pos_sout[i] <= sadd(ctx_s[S_P5].pos[i], qsat(vp_s[i]));
			else
				pos_sout[i] <= ctx_s[S_P5].pos[i];
		end
		if (ctx_s[S_P5].alive && fen)
			frame_sout <= first_q + md_rem_s[S_P5][15:0];
		else
			frame_sout <= ctx_s[S_P5].frame;
	end

	assign done = v_s[S_OUT];
	assign still_alive = alive_sout;
	assign age_out = age_sout;
	assign new_pos_x = pos_sout[0];
	assign new_pos_y = pos_sout[1];
	assign new_pos_z = pos_sout[2];
	assign new_vel_x = vel_sout[0];
	assign new_vel_y = vel_sout[1];
	assign new_vel_z = vel_sout[2];
	assign angle_out = angle_sout;
	assign frame_out = frame_sout;

	// ---------------- assertions ----------------
	`PMU_ASSERT_NXT(a_enter, acc, v_s[1], "accepted beat did not enter the pipeline")
	`PMU_ASSERT_IMP(a_dead_hold, done && !still_alive, new_vel_x == $past(vel_x, S_OUT) && new_pos_z == $past(pos_z, S_OUT), "dead particle record changed")
	`PMU_ASSERT_IMP(a_frame_win, done && still_alive && fen, frame_out >= first_q && frame_out <= last_q, "frame outside window")
	`PMU_ASSERT_IMP(a_age_grow, done, age_out >= $past(age_in, S_OUT), "age went backward")

endmodule
